FILE: rtl/wall_follow_avoid_controller_macros.svh
// ----------------------------------------------------------------------------
// wall_follow_avoid_controller_macros
// Assertion macros used by the wall-follow controller top module.
// ----------------------------------------------------------------------------
`ifndef WALL_FOLLOW_AVOID_CONTROLLER_MACROS_SVH
`define WALL_FOLLOW_AVOID_CONTROLLER_MACROS_SVH

// same-cycle implication
`define WFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfa assertion failed");

// next-cycle implication
`define WFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfa assertion failed");

`endif

FILE: rtl/wfa_pkg.sv
// ----------------------------------------------------------------------------
// wfa_pkg
// Types and constants of the wall-follow drive sequencer.
// ----------------------------------------------------------------------------
package wfa_pkg;

    localparam int unsigned DIST_W = 10;
    localparam int unsigned CNT_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [DIST_W:0]  STEER_DEADZONE = 11'd2;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_WALL  = 3'd0,
        REG_FRONT_TURN = 3'd1,
        REG_CRASH      = 3'd2,
        REG_CRASH_SMP  = 3'd3,
        REG_COOLDOWN   = 3'd4,
        REG_DECEL      = 3'd5,
        REG_BACKOFF    = 3'd6,
        REG_PIVOT      = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        M_STRAIGHT = 4'd0,
        M_DECEL_R  = 4'd1,
        M_DECEL_L  = 4'd2,
        M_TURN_R   = 4'd3,
        M_TURN_L   = 4'd4,
        M_BRAKE    = 4'd5,
        M_BACKOFF  = 4'd6,
        M_PIVOT_R  = 4'd7,
        M_PIVOT_L  = 4'd8
    } t_mode;

    typedef struct packed {
        logic [DIST_W-1:0] near_wall_cm;
        logic [DIST_W-1:0] front_turn_cm;
        logic [DIST_W-1:0] crash_dist;
        logic [CNT_W-1:0]  crash_samples;
        logic [CNT_W-1:0]  cooldown_ticks;
        logic [CNT_W-1:0]  decel_ticks;
        logic [CNT_W-1:0]  reverse_ticks;
        logic [CNT_W-1:0]  turn_limit;
    } t_cfg;

    typedef struct packed {
        t_mode            mode;
        logic [CNT_W-1:0] tick;
        logic [CNT_W-1:0] streak;
        logic [CNT_W-1:0] cooldown;
        logic             left_dir;
        logic             right_dir;
    } t_state;

    typedef struct packed {
        logic [DIST_W-1:0] left_dist;
        logic [DIST_W-1:0] right_dist;
        logic [DIST_W-1:0] front_dist;
    } t_in_word;

    typedef struct packed {
        logic       left_forward;
        logic       right_forward;
        logic [1:0] both_step;
        logic [1:0] left_step;
        logic [1:0] right_step;
        logic [3:0] drive_mode;
    } t_out_word;

endpackage

FILE: rtl/wfa_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfa_cfg_regs
// Threshold and tick-count register file, written through a plain port.
// ----------------------------------------------------------------------------
module wfa_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output wfa_pkg::t_cfg                   o_cfg
);

    wfa_pkg::t_cfg r_cfg;
    wfa_pkg::t_cfg n_cfg;
    logic [wfa_pkg::CNT_W-1:0] w_data8;

    assign w_data8 = i_cfg_data[wfa_pkg::CNT_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (wfa_pkg::t_reg_idx'(i_cfg_idx))
                wfa_pkg::REG_NEAR_WALL:  n_cfg.near_wall_cm   = i_cfg_data;
                wfa_pkg::REG_FRONT_TURN: n_cfg.front_turn_cm  = i_cfg_data;
                wfa_pkg::REG_CRASH:      n_cfg.crash_dist     = i_cfg_data;
                wfa_pkg::REG_CRASH_SMP:  n_cfg.crash_samples  = w_data8;
                wfa_pkg::REG_COOLDOWN:   n_cfg.cooldown_ticks = w_data8;
                wfa_pkg::REG_DECEL:      n_cfg.decel_ticks    = w_data8;
                wfa_pkg::REG_BACKOFF:    n_cfg.reverse_ticks  = w_data8;
                wfa_pkg::REG_PIVOT:      n_cfg.turn_limit     = w_data8;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_wall_cm   <= 10'd65;
            r_cfg.front_turn_cm  <= 10'd55;
            r_cfg.crash_dist     <= 10'd18;
            r_cfg.crash_samples  <= 8'd1;
            r_cfg.cooldown_ticks <= 8'd40;
            r_cfg.decel_ticks    <= 8'd10;
            r_cfg.reverse_ticks  <= 8'd20;
            r_cfg.turn_limit     <= 8'd25;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/wfa_step.sv
// ----------------------------------------------------------------------------
// wfa_step
// One tick of the drive sequencer: crash guard, next state and step commands.
// ----------------------------------------------------------------------------
module wfa_step (
    input  wfa_pkg::t_cfg      i_cfg,
    input  wfa_pkg::t_state    i_state,
    input  wfa_pkg::t_in_word  i_word,
    output wfa_pkg::t_state    o_state,
    output wfa_pkg::t_out_word o_word
);

    logic [wfa_pkg::CNT_W-1:0]  w_cd_dec;
    logic                       w_chk;
    logic [wfa_pkg::CNT_W-1:0]  w_streak_chk;
    logic                       w_fire;
    wfa_pkg::t_mode             w_mode1;
    logic [wfa_pkg::CNT_W-1:0]  w_tick1;
    logic [wfa_pkg::CNT_W-1:0]  w_tick_inc;
    logic [wfa_pkg::DIST_W:0]   w_left_x;
    logic [wfa_pkg::DIST_W:0]   w_right_x;
    logic                       w_near;
    logic [1:0]                 w_both;
    logic [1:0]                 w_ls;
    logic [1:0]                 w_rs;
    wfa_pkg::t_state            n_state;

    assign w_cd_dec = (i_state.cooldown != '0) ? i_state.cooldown - wfa_pkg::CNT_ONE : '0;
    assign w_chk = (w_cd_dec == '0) &&
                   ((i_state.mode == wfa_pkg::M_STRAIGHT) ||
                    (i_state.mode == wfa_pkg::M_TURN_R) ||
                    (i_state.mode == wfa_pkg::M_TURN_L));
    assign w_streak_chk = (i_word.front_dist > i_cfg.crash_dist) ? '0 :
                          (i_state.streak == wfa_pkg::CNT_MAX) ? wfa_pkg::CNT_MAX :
                          i_state.streak + wfa_pkg::CNT_ONE;
    assign w_fire  = w_chk && (w_streak_chk >= i_cfg.crash_samples);
    assign w_mode1 = w_fire ? wfa_pkg::M_BRAKE : i_state.mode;
    assign w_tick1 = w_fire ? '0 : i_state.tick;
    assign w_tick_inc = (w_tick1 == wfa_pkg::CNT_MAX) ? wfa_pkg::CNT_MAX :
                        w_tick1 + wfa_pkg::CNT_ONE;

    assign w_left_x  = {1'b0, i_word.left_dist};
    assign w_right_x = {1'b0, i_word.right_dist};
    assign w_near = (i_word.front_dist <= i_cfg.near_wall_cm) ||
                    (i_word.left_dist <= i_cfg.near_wall_cm) ||
                    (i_word.right_dist <= i_cfg.near_wall_cm);

    always_comb begin
        n_state          = i_state;
        n_state.cooldown = w_cd_dec;
        n_state.streak   = w_chk ? w_streak_chk : i_state.streak;
        n_state.mode     = w_mode1;
        n_state.tick     = w_tick1;
        unique case (w_mode1)
            wfa_pkg::M_DECEL_R, wfa_pkg::M_DECEL_L: begin
                n_state.tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.decel_ticks) begin
                    if (w_mode1 == wfa_pkg::M_DECEL_R) begin
                        n_state.left_dir  = 1'b1;
                        n_state.right_dir = 1'b0;
                        n_state.mode      = wfa_pkg::M_TURN_R;
                    end else begin
                        n_state.left_dir  = 1'b0;
                        n_state.right_dir = 1'b1;
                        n_state.mode      = wfa_pkg::M_TURN_L;
                    end
                end
            end
            wfa_pkg::M_TURN_R, wfa_pkg::M_TURN_L: begin
                n_state.tick = w_tick_inc;
                if ((w_mode1 == wfa_pkg::M_TURN_R) ?
                        (i_word.front_dist > i_word.right_dist) :
                        (i_word.front_dist > i_word.left_dist)) begin
                    n_state.tick = '0;
                end
                if ((n_state.tick == '0) || (w_tick_inc >= i_cfg.turn_limit)) begin
                    n_state.left_dir  = 1'b1;
                    n_state.right_dir = 1'b1;
                    n_state.mode      = wfa_pkg::M_STRAIGHT;
                    n_state.tick      = '0;
                end
            end
            wfa_pkg::M_BRAKE: begin
                n_state.tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.decel_ticks) begin
                    n_state.left_dir  = 1'b0;
                    n_state.right_dir = 1'b0;
                    n_state.mode      = wfa_pkg::M_BACKOFF;
                    n_state.tick      = '0;
                end
            end
            wfa_pkg::M_BACKOFF: begin
                n_state.tick = w_tick_inc;
                if (w_tick_inc >= i_cfg.reverse_ticks) begin
                    if (i_word.right_dist >= i_word.left_dist) begin
                        n_state.left_dir  = 1'b1;
                        n_state.right_dir = 1'b0;
                        n_state.mode      = wfa_pkg::M_PIVOT_R;
                    end else begin
                        n_state.left_dir  = 1'b0;
                        n_state.right_dir = 1'b1;
                        n_state.mode      = wfa_pkg::M_PIVOT_L;
                    end
                    n_state.tick = '0;
                end
            end
            wfa_pkg::M_PIVOT_R, wfa_pkg::M_PIVOT_L: begin
                if ((w_mode1 == wfa_pkg::M_PIVOT_R) ?
                        (i_word.front_dist > i_word.left_dist) :
                        (i_word.front_dist > i_word.right_dist)) begin
                    n_state.tick = w_tick1;
                end else begin
                    n_state.tick = w_tick_inc;
                end
                if ((n_state.tick == w_tick1) && (w_tick_inc != w_tick1) ||
                    ((w_mode1 == wfa_pkg::M_PIVOT_R) ?
                        (i_word.front_dist > i_word.left_dist) :
                        (i_word.front_dist > i_word.right_dist)) ||
                    (w_tick_inc >= i_cfg.turn_limit)) begin
                    n_state.left_dir  = 1'b1;
                    n_state.right_dir = 1'b1;
                    n_state.mode      = wfa_pkg::M_STRAIGHT;
                    n_state.cooldown  = i_cfg.cooldown_ticks;
                    n_state.streak    = '0;
                end
            end
            default: begin
                n_state.left_dir  = 1'b1;
                n_state.right_dir = 1'b1;
                if (i_word.front_dist <= i_cfg.front_turn_cm) begin
                    n_state.tick = '0;
                    n_state.mode = (i_word.right_dist >= i_word.left_dist) ?
                                   wfa_pkg::M_DECEL_R : wfa_pkg::M_DECEL_L;
                end
            end
        endcase
    end

    always_comb begin
        w_both = wfa_pkg::STEP_NONE;
        w_ls   = wfa_pkg::STEP_NONE;
        w_rs   = wfa_pkg::STEP_NONE;
        unique case (w_mode1)
            wfa_pkg::M_DECEL_R, wfa_pkg::M_DECEL_L: begin
                w_ls = wfa_pkg::STEP_DOWN;
                w_rs = wfa_pkg::STEP_DOWN;
            end
            wfa_pkg::M_TURN_R, wfa_pkg::M_TURN_L: begin
                w_both = (i_word.front_dist <= i_cfg.near_wall_cm) ?
                         wfa_pkg::STEP_DOWN : wfa_pkg::STEP_UP;
            end
            wfa_pkg::M_BRAKE: begin
                w_both = wfa_pkg::STEP_DOWN;
                w_ls   = wfa_pkg::STEP_DOWN;
                w_rs   = wfa_pkg::STEP_DOWN;
            end
            wfa_pkg::M_BACKOFF: begin
                w_both = wfa_pkg::STEP_DOWN;
            end
            wfa_pkg::M_PIVOT_R, wfa_pkg::M_PIVOT_L: begin
                w_both = wfa_pkg::STEP_UP;
            end
            default: begin
                w_both = w_near ? wfa_pkg::STEP_DOWN : wfa_pkg::STEP_UP;
                if (w_right_x > w_left_x + wfa_pkg::STEER_DEADZONE) begin
                    w_ls = wfa_pkg::STEP_UP;
                    w_rs = wfa_pkg::STEP_DOWN;
                end else if (w_left_x > w_right_x + wfa_pkg::STEER_DEADZONE) begin
                    w_ls = wfa_pkg::STEP_DOWN;
                    w_rs = wfa_pkg::STEP_UP;
                end
            end
        endcase
    end

    assign o_state = n_state;

    assign o_word.left_forward  = n_state.left_dir;
    assign o_word.right_forward = n_state.right_dir;
    assign o_word.both_step     = w_both;
    assign o_word.left_step     = w_ls;
    assign o_word.right_step    = w_rs;
    assign o_word.drive_mode    = n_state.mode;

endmodule

FILE: rtl/wall_follow_avoid_controller.sv
// ----------------------------------------------------------------------------
// wall_follow_avoid_controller
// Wall-following drive sequencer with a crash guard, one tick per word.
//
//   channel   handshake                   payload
//   input     i_in_valid / o_in_ready     i_in_word  (left, right, front cm)
//   output    o_out_valid / i_out_ready   o_out_word (dirs, steps, mode)
//   config    i_cfg_wr_en                 i_cfg_idx, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted
// word passes the input register, then the state update into the output register.
// The sequencer state advances when the input register moves a word on.
// Reset is synchronous and active low; a stall on the output holds the
// input register, and o_in_ready drops only when both registers are full
// and the output word is not taken.
// ----------------------------------------------------------------------------
`include "wall_follow_avoid_controller_macros.svh"

module wall_follow_avoid_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wfa_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wfa_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_wr_en,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    wfa_pkg::t_cfg      w_cfg;
    logic               r_in_valid;
    wfa_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    wfa_pkg::t_out_word r_out_word;
    wfa_pkg::t_state    r_state;
    wfa_pkg::t_state    n_state;
    wfa_pkg::t_out_word n_out_word;
    logic               w_out_free;
    logic               w_adv;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    wfa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    wfa_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_word  (r_in_word),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= wfa_pkg::M_STRAIGHT;
            r_state.tick      <= '0;
            r_state.streak    <= '0;
            r_state.cooldown  <= '0;
            r_state.left_dir  <= 1'b1;
            r_state.right_dir <= 1'b1;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `WFA_ASSERT_IMP(a_backoff_reverse, i_clk, i_rst_n, r_state.mode == wfa_pkg::M_BACKOFF, !r_state.left_dir && !r_state.right_dir)
    `WFA_ASSERT_IMP(a_straight_forward, i_clk, i_rst_n, r_state.mode == wfa_pkg::M_STRAIGHT, r_state.left_dir && r_state.right_dir)
    `WFA_ASSERT_NXT(a_adv_shows_word, i_clk, i_rst_n, w_adv, o_out_valid && (o_out_word.drive_mode == r_state.mode))

endmodule

FILE: tb/tb_wall_follow_avoid_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wall_follow_avoid_controller
// Self-checking bench for the wall-follow drive sequencer. Distance words
// go in over valid/ready. A scoreboard class keeps its own copy of the
// sequencer state and settings and predicts each drive word. Every word
// that comes out is compared field by field in order. The run walks
// through directed turn and guard sequences, then random readings aimed at
// the distance thresholds. It uses several register settings (minimum,
// maximum, zero crash streak) and several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_wall_follow_avoid_controller;

    localparam int unsigned CYCLE_LIMIT = 500000;

    class drive_word_scoreboard;
        wfa_pkg::t_cfg      cfg;
        wfa_pkg::t_mode     mode;
        logic [7:0]         ticks;
        logic [7:0]         streak;
        logic [7:0]         cooldown;
        logic               left_dir;
        logic               right_dir;
        wfa_pkg::t_out_word expected_drive_words[$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            cfg = '{near_wall_cm: 10'd65, front_turn_cm: 10'd55, crash_dist: 10'd18,
                    crash_samples: 8'd1, cooldown_ticks: 8'd40, decel_ticks: 8'd10,
                    reverse_ticks: 8'd20, turn_limit: 8'd25};
            mode = wfa_pkg::M_STRAIGHT;
            ticks = '0;
            streak = '0;
            cooldown = '0;
            left_dir = 1'b1;
            right_dir = 1'b1;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(wfa_pkg::t_reg_idx idx, logic [9:0] value);
            case (idx)
                wfa_pkg::REG_NEAR_WALL:  cfg.near_wall_cm = value;
                wfa_pkg::REG_FRONT_TURN: cfg.front_turn_cm = value;
                wfa_pkg::REG_CRASH:      cfg.crash_dist = value;
                wfa_pkg::REG_CRASH_SMP:  cfg.crash_samples = value[7:0];
                wfa_pkg::REG_COOLDOWN:   cfg.cooldown_ticks = value[7:0];
                wfa_pkg::REG_DECEL:      cfg.decel_ticks = value[7:0];
                wfa_pkg::REG_BACKOFF:    cfg.reverse_ticks = value[7:0];
                wfa_pkg::REG_PIVOT:      cfg.turn_limit = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] advance_tick();
            if (ticks != wfa_pkg::CNT_MAX) ticks++;
            return ticks;
        endfunction

        function void disarm_guard();
            left_dir = 1'b1;
            right_dir = 1'b1;
            mode = wfa_pkg::M_STRAIGHT;
            cooldown = cfg.cooldown_ticks;
            streak = '0;
        endfunction

        function void note_tick(wfa_pkg::t_in_word w);
            wfa_pkg::t_out_word want;
            logic [1:0]         both_s;
            logic [1:0]         left_s;
            logic [1:0]         right_s;
            logic [9:0]         inner;
            logic               done;
            int                 err;
            int                 deadzone;
            both_s = wfa_pkg::STEP_NONE;
            left_s = wfa_pkg::STEP_NONE;
            right_s = wfa_pkg::STEP_NONE;
            deadzone = wfa_pkg::STEER_DEADZONE;
            if (cooldown != 0) cooldown--;
            if (cooldown == 0 &&
                mode inside {wfa_pkg::M_STRAIGHT, wfa_pkg::M_TURN_R, wfa_pkg::M_TURN_L}) begin
                if (w.front_dist <= cfg.crash_dist) begin
                    if (streak != wfa_pkg::CNT_MAX) streak++;
                end else begin
                    streak = '0;
                end
                if (streak >= cfg.crash_samples) begin
                    mode = wfa_pkg::M_BRAKE;
                    ticks = '0;
                end
            end
            case (mode)
                wfa_pkg::M_DECEL_R, wfa_pkg::M_DECEL_L: begin
                    left_s = wfa_pkg::STEP_DOWN;
                    right_s = wfa_pkg::STEP_DOWN;
                    if (advance_tick() >= cfg.decel_ticks) begin
                        if (mode == wfa_pkg::M_DECEL_R) begin
                            left_dir = 1'b1;
                            right_dir = 1'b0;
                            mode = wfa_pkg::M_TURN_R;
                        end else begin
                            left_dir = 1'b0;
                            right_dir = 1'b1;
                            mode = wfa_pkg::M_TURN_L;
                        end
                    end
                end
                wfa_pkg::M_TURN_R, wfa_pkg::M_TURN_L: begin
                    inner = (mode == wfa_pkg::M_TURN_R) ? w.right_dist : w.left_dist;
                    both_s = (w.front_dist <= cfg.near_wall_cm) ?
                             wfa_pkg::STEP_DOWN : wfa_pkg::STEP_UP;
                    done = (w.front_dist > inner);
                    if (!done) done = (advance_tick() >= cfg.turn_limit);
                    if (done) begin
                        left_dir = 1'b1;
                        right_dir = 1'b1;
                        mode = wfa_pkg::M_STRAIGHT;
                        ticks = '0;
                    end
                end
                wfa_pkg::M_BRAKE: begin
                    both_s = wfa_pkg::STEP_DOWN;
                    left_s = wfa_pkg::STEP_DOWN;
                    right_s = wfa_pkg::STEP_DOWN;
                    if (advance_tick() >= cfg.decel_ticks) begin
                        left_dir = 1'b0;
                        right_dir = 1'b0;
                        mode = wfa_pkg::M_BACKOFF;
                        ticks = '0;
                    end
                end
                wfa_pkg::M_BACKOFF: begin
                    both_s = wfa_pkg::STEP_DOWN;
                    if (advance_tick() >= cfg.reverse_ticks) begin
                        if (w.right_dist >= w.left_dist) begin
                            left_dir = 1'b1;
                            right_dir = 1'b0;
                            mode = wfa_pkg::M_PIVOT_R;
                        end else begin
                            left_dir = 1'b0;
                            right_dir = 1'b1;
                            mode = wfa_pkg::M_PIVOT_L;
                        end
                        ticks = '0;
                    end
                end
                wfa_pkg::M_PIVOT_R, wfa_pkg::M_PIVOT_L: begin
                    both_s = wfa_pkg::STEP_UP;
                    inner = (mode == wfa_pkg::M_PIVOT_R) ? w.left_dist : w.right_dist;
                    done = (w.front_dist > inner);
                    if (!done) done = (advance_tick() >= cfg.turn_limit);
                    if (done) disarm_guard();
                end
                default: begin
                    err = int'(w.right_dist) - int'(w.left_dist);
                    left_dir = 1'b1;
                    right_dir = 1'b1;
                    if (w.front_dist <= cfg.near_wall_cm || w.left_dist <= cfg.near_wall_cm ||
                        w.right_dist <= cfg.near_wall_cm) begin
                        both_s = wfa_pkg::STEP_DOWN;
                    end else begin
                        both_s = wfa_pkg::STEP_UP;
                    end
                    if (err > deadzone) begin
                        left_s = wfa_pkg::STEP_UP;
                        right_s = wfa_pkg::STEP_DOWN;
                    end else if (err < -deadzone) begin
                        right_s = wfa_pkg::STEP_UP;
                        left_s = wfa_pkg::STEP_DOWN;
                    end
                    if (w.front_dist <= cfg.front_turn_cm) begin
                        ticks = '0;
                        mode = (w.right_dist >= w.left_dist) ?
                               wfa_pkg::M_DECEL_R : wfa_pkg::M_DECEL_L;
                    end
                end
            endcase
            want.left_forward = left_dir;
            want.right_forward = right_dir;
            want.both_step = both_s;
            want.left_step = left_s;
            want.right_step = right_s;
            want.drive_mode = mode;
            expected_drive_words.push_back(want);
        endfunction

        function string word_text(wfa_pkg::t_out_word w);
            return $sformatf("dir %b/%b step %0d/%0d/%0d mode %0d", w.left_forward,
                             w.right_forward, w.both_step, w.left_step, w.right_step,
                             w.drive_mode);
        endfunction

        function void check_word(wfa_pkg::t_out_word got);
            wfa_pkg::t_out_word want;
            if (expected_drive_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word: %s", word_text(got));
                return;
            end
            want = expected_drive_words.pop_front();
            if (got.left_forward !== want.left_forward ||
                got.right_forward !== want.right_forward ||
                got.both_step !== want.both_step || got.left_step !== want.left_step ||
                got.right_step !== want.right_step || got.drive_mode !== want.drive_mode) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("word %0d: expected %s, got %s", checked, word_text(want),
                             word_text(got));
                end
            end
            checked++;
        endfunction

        function int pending();
            return expected_drive_words.size();
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_in_valid;
    logic                                   o_in_ready;
    wfa_pkg::t_in_word                      i_in_word;
    logic                                   o_out_valid;
    logic                                   i_out_ready;
    wfa_pkg::t_out_word                     o_out_word;
    logic                                   i_cfg_wr_en;
    logic [wfa_pkg::CFG_IDX_W-1:0]          i_cfg_idx;
    logic [wfa_pkg::CFG_DATA_W-1:0]         i_cfg_data;

    drive_word_scoreboard   board;
    int unsigned            send_idle_pct;
    int unsigned            recv_stall_pct;
    int unsigned            setting[8];
    int unsigned            cycle_count;

    wall_follow_avoid_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("wall_follow_avoid_controller regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out_word);
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_tick(wfa_pkg::t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_tick(w);
    endtask

    task automatic send_cm(int unsigned l, int unsigned r, int unsigned f);
        send_tick({l[9:0], r[9:0], f[9:0]});
    endtask

    // drop valid, then wait for every drive word to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(wfa_pkg::t_reg_idx idx, int unsigned value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[9:0];
        @(posedge i_clk);
        board.set_reg(idx, value[9:0]);
    endtask

    task automatic load_setting();
        wfa_pkg::t_reg_idx idx;
        idx = wfa_pkg::REG_NEAR_WALL;
        repeat (idx.num()) begin
            write_reg(idx, setting[idx]);
            idx = idx.next();
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [9:0] clamp_cm(int v);
        if (v < 0) return 10'd0;
        if (v > 1023) return 10'd1023;
        return v[9:0];
    endfunction

    // bias readings toward the current thresholds and the range ends
    function automatic logic [9:0] pick_dist();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 1023;
            2, 3: begin
                case ($urandom_range(0, 2))
                    0: v = board.cfg.near_wall_cm;
                    1: v = board.cfg.front_turn_cm;
                    default: v = board.cfg.crash_dist;
                endcase
                v = v + int'($urandom_range(0, 6)) - 3;
            end
            4, 5, 6: v = $urandom_range(0, 120);
            default: v = $urandom_range(0, 1023);
        endcase
        return clamp_cm(v);
    endfunction

    function automatic wfa_pkg::t_in_word make_reading();
        wfa_pkg::t_in_word w;
        w.left_dist = pick_dist();
        if ($urandom_range(0, 3) == 0) begin
            w.right_dist = clamp_cm(int'(w.left_dist) + int'($urandom_range(0, 8)) - 4);
        end else begin
            w.right_dist = pick_dist();
        end
        w.front_dist = pick_dist();
        return w;
    endfunction

    initial begin
        int unsigned n_items;
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cm(1023, 1023, 1023);
        send_cm(100, 103, 1023);
        send_cm(100, 102, 1023);
        send_cm(103, 100, 1023);
        send_cm(0, 1023, 1023);
        send_cm(60, 500, 66);
        send_cm(200, 200, 56);
        send_cm(200, 200, 55);
        drain();

        setting = '{65, 55, 18, 1, 3, 2, 2, 3};
        load_setting();
        send_cm(200, 300, 500);
        send_cm(200, 300, 500);
        send_cm(200, 300, 40);
        send_cm(200, 300, 400);
        send_cm(300, 200, 50);
        send_cm(300, 200, 500);
        send_cm(300, 200, 500);
        send_cm(300, 200, 100);
        send_cm(400, 400, 18);
        repeat (4) send_cm(400, 400, 0);
        send_cm(400, 400, 1023);
        repeat (4) send_cm(500, 100, 0);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: setting = '{65, 55, 18, 1, 40, 10, 20, 25};
                1: setting = '{1023, 0, 0, 1, 0, 1, 1, 1};
                2: setting = '{0, 1023, 1023, 255, 255, 255, 255, 255};
                3: setting = '{0, 0, 1023, 255, 255, 1, 1, 1};
                4: setting = '{65, 55, 18, 0, 5, 3, 4, 6};
                default: setting = '{$urandom_range(0, 200), $urandom_range(0, 150),
                                      $urandom_range(0, 60), $urandom_range(1, 4),
                                      $urandom_range(0, 30), $urandom_range(1, 12),
                                      $urandom_range(1, 12), $urandom_range(1, 20)};
            endcase
            case (p)
                2, 4: n_items = 100;
                3: n_items = 300;
                5, 6, 7: n_items = 110;
                default: n_items = 140;
            endcase
            case (p % 4)
                1: begin
                    send_idle_pct = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 75;
                end
                3: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            load_setting();
            repeat (n_items) send_tick(make_reading());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("wall_follow_avoid_controller regression: pass");
        end else begin
            $display("wall_follow_avoid_controller regression: fail");
        end
        $finish;
    end
endmodule
